[hw/rtl/rets_pkg.sv]
// Shared types and constants for the recent event trace ring.
// No dependencies; every other file of the block imports this package.
package rets_pkg;

    localparam int RING_DEPTH = 64;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_DUMP   = 2'd1,
        OP_RANGE  = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CNT_RD,
        ST_CNT_CHK,
        ST_PLAN,
        ST_EM_RD,
        ST_EM_CHK,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [31:0] tm;
        logic [15:0] src;
        logic [7:0]  code;
        logic [7:0]  sev;
        logic [31:0] a1;
        logic [31:0] a2;
        logic [31:0] a3;
        logic [31:0] a4;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] time_stamp;
        logic [15:0] source_id;
        logic [7:0]  event_code;
        logic [7:0]  severity;
        logic [31:0] arg1;
        logic [31:0] arg2;
        logic [31:0] arg3;
        logic [31:0] arg4;
        logic [15:0] request_count;
        logic [15:0] start_offset;
        logic        filter_by_source;
    } t_in_item;

    typedef struct packed {
        logic [31:0]      time_out;
        logic [15:0]      source_out;
        logic [7:0]       event_out;
        logic [7:0]       severity_out;
        logic [31:0]      arg1_out;
        logic [31:0]      arg2_out;
        logic [31:0]      arg3_out;
        logic [31:0]      arg4_out;
        logic             has_event;
        logic             last_of_run;
        logic [CNT_W-1:0] stored_count;
    } t_out_item;

endpackage

[hw/rtl/rets_if.sv]
// Valid/ready channel interfaces for the trace ring request and result streams.
// Depends on rets_pkg for the payload structs.
interface rets_in_if
    import rets_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rets_out_if
    import rets_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/rets_store.sv]
// Event storage: one write port, one read port with registered read data.
// Depends on rets_pkg; contents are undefined until written.
module rets_store
    import rets_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rd_data
);

    t_entry r_mem [RING_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/rets_ctrl.sv]
// Sequencer of the trace ring: ring pointers, scan walker with its source
// compare and counters, and the result register. Depends on rets_pkg.
module rets_ctrl
    import rets_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item,
    output t_mem_req  o_mem_req,
    input  t_entry    i_rd_data
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_held, n_held;
    logic [IDX_W-1:0] r_wslot, n_wslot;

    logic [IDX_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0] r_left, n_left;
    logic [CNT_W-1:0] r_match, n_match;
    logic [CNT_W-1:0] r_total, n_total;
    logic [CNT_W-1:0] r_skip, n_skip;
    logic             r_filt, n_filt;
    logic [15:0]      r_want, n_want;
    logic [CNT_W-1:0] r_req, n_req;
    t_entry           r_out_ev, n_out_ev;
    logic             r_out_has, n_out_has;
    logic             r_out_last, n_out_last;

    logic             in_acc;
    logic [CNT_W-1:0] req_sat;
    logic [CNT_W-1:0] take_dump;
    logic [CNT_W-1:0] avail;
    logic [CNT_W-1:0] take_range;
    logic             range_ok;
    logic [CNT_W-1:0] start_pos;
    logic [SUM_W-1:0] oldest_sum;
    logic [IDX_W-1:0] start_slot;
    logic [IDX_W-1:0] oldest_slot;
    logic [IDX_W-1:0] slot_inc;
    logic [IDX_W-1:0] wslot_inc;
    logic [CNT_W-1:0] plan_total;
    logic             hit;

    function automatic logic [IDX_W-1:0] wrap_slot(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        begin
            t = (s >= SUM_W'(RING_DEPTH)) ? s - SUM_W'(RING_DEPTH) : s;
            return t[IDX_W-1:0];
        end
    endfunction

    // Decode and shared scan arithmetic
    always_comb begin
        in_acc     = i_in_valid && (r_state == ST_IDLE);
        req_sat    = (i_in_item.request_count > 16'(RING_DEPTH)) ? CNT_W'(RING_DEPTH)
                                                                 : i_in_item.request_count[CNT_W-1:0];
        take_dump  = (r_held < req_sat) ? r_held : req_sat;
        range_ok   = (req_sat != '0) && (16'(r_held) > i_in_item.start_offset);
        avail      = r_held - i_in_item.start_offset[CNT_W-1:0];
        take_range = (avail < req_sat) ? avail : req_sat;
        oldest_sum = SUM_W'(r_wslot) + SUM_W'(RING_DEPTH) - SUM_W'(r_held);
        case (t_op'(i_in_item.op))
            OP_DUMP:  start_pos = i_in_item.filter_by_source ? '0 : r_held - take_dump;
            OP_RANGE: start_pos = i_in_item.start_offset[CNT_W-1:0];
            default:  start_pos = '0;
        endcase
        start_slot  = wrap_slot(oldest_sum + SUM_W'(start_pos));
        oldest_slot = wrap_slot(oldest_sum);
        slot_inc    = (r_slot == IDX_W'(RING_DEPTH - 1)) ? '0 : r_slot + 1'b1;
        wslot_inc   = (r_wslot == IDX_W'(RING_DEPTH - 1)) ? '0 : r_wslot + 1'b1;
        plan_total  = (r_match < r_req) ? r_match : r_req;
        hit         = !r_filt || (i_rd_data.src == r_want);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (t_op'(i_in_item.op))
                        OP_RECORD: n_state = ST_OUT;
                        OP_CLEAR:  n_state = ST_OUT;
                        OP_DUMP: begin
                            if (req_sat == '0) begin
                                n_state = ST_OUT;
                            end else if (i_in_item.filter_by_source) begin
                                n_state = (r_held == '0) ? ST_OUT : ST_CNT_RD;
                            end else begin
                                n_state = (take_dump == '0) ? ST_OUT : ST_EM_RD;
                            end
                        end
                        OP_RANGE:  n_state = range_ok ? ST_EM_RD : ST_OUT;
                        default:   n_state = ST_OUT;
                    endcase
                end
            end
            ST_CNT_RD:  n_state = ST_CNT_CHK;
            ST_CNT_CHK: n_state = (r_left == CNT_W'(1)) ? ST_PLAN : ST_CNT_RD;
            ST_PLAN:    n_state = (plan_total == '0) ? ST_OUT : ST_EM_RD;
            ST_EM_RD:   n_state = ST_EM_CHK;
            ST_EM_CHK:  n_state = (hit && (r_skip == '0)) ? ST_OUT : ST_EM_RD;
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = r_out_last ? ST_IDLE : ST_EM_RD;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // Datapath and memory port
    always_comb begin
        n_held     = r_held;
        n_wslot    = r_wslot;
        n_slot     = r_slot;
        n_left     = r_left;
        n_match    = r_match;
        n_total    = r_total;
        n_skip     = r_skip;
        n_filt     = r_filt;
        n_want     = r_want;
        n_req      = r_req;
        n_out_ev   = r_out_ev;
        n_out_has  = r_out_has;
        n_out_last = r_out_last;

        o_mem_req.we         = 1'b0;
        o_mem_req.waddr      = r_wslot;
        o_mem_req.wdata.tm   = i_in_item.time_stamp;
        o_mem_req.wdata.src  = i_in_item.source_id;
        o_mem_req.wdata.code = i_in_item.event_code;
        o_mem_req.wdata.sev  = i_in_item.severity;
        o_mem_req.wdata.a1   = i_in_item.arg1;
        o_mem_req.wdata.a2   = i_in_item.arg2;
        o_mem_req.wdata.a3   = i_in_item.arg3;
        o_mem_req.wdata.a4   = i_in_item.arg4;
        o_mem_req.re         = (r_state == ST_CNT_RD) || (r_state == ST_EM_RD);
        o_mem_req.raddr      = r_slot;

        case (r_state)
            ST_IDLE: begin
                // Preload an acknowledgement; a scan overwrites it later
                n_out_ev   = '0;
                n_out_has  = 1'b0;
                n_out_last = 1'b1;
                // Only a dump filters on source
                n_filt     = i_in_item.filter_by_source && (t_op'(i_in_item.op) == OP_DUMP);
                n_want     = i_in_item.source_id;
                n_req      = req_sat;
                n_slot     = start_slot;
                n_left     = r_held;
                n_match    = '0;
                n_skip     = '0;
                n_total    = (t_op'(i_in_item.op) == OP_RANGE) ? take_range : take_dump;
                if (in_acc) begin
                    case (t_op'(i_in_item.op))
                        OP_RECORD: begin
                            o_mem_req.we = 1'b1;
                            n_wslot      = wslot_inc;
                            n_held       = (r_held == CNT_W'(RING_DEPTH)) ? r_held
                                                                          : r_held + 1'b1;
                        end
                        OP_CLEAR: begin
                            n_wslot = '0;
                            n_held  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CNT_CHK: begin
                if (i_rd_data.src == r_want) begin
                    n_match = r_match + 1'b1;
                end
                n_left = r_left - 1'b1;
                n_slot = slot_inc;
            end
            ST_PLAN: begin
                n_total = plan_total;
                n_skip  = r_match - plan_total;
                n_slot  = oldest_slot;
            end
            ST_EM_CHK: begin
                n_slot = slot_inc;
                if (hit) begin
                    if (r_skip != '0) begin
                        n_skip = r_skip - 1'b1;
                    end else begin
                        n_out_ev   = i_rd_data;
                        n_out_has  = 1'b1;
                        n_out_last = (r_total == CNT_W'(1));
                        n_total    = r_total - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_held  <= '0;
            r_wslot <= '0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_wslot <= n_wslot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot     <= n_slot;
        r_left     <= n_left;
        r_match    <= n_match;
        r_total    <= n_total;
        r_skip     <= n_skip;
        r_filt     <= n_filt;
        r_want     <= n_want;
        r_req      <= n_req;
        r_out_ev   <= n_out_ev;
        r_out_has  <= n_out_has;
        r_out_last <= n_out_last;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);

    always_comb begin
        o_out_item.time_out     = r_out_ev.tm;
        o_out_item.source_out   = r_out_ev.src;
        o_out_item.event_out    = r_out_ev.code;
        o_out_item.severity_out = r_out_ev.sev;
        o_out_item.arg1_out     = r_out_ev.a1;
        o_out_item.arg2_out     = r_out_ev.a2;
        o_out_item.arg3_out     = r_out_ev.a3;
        o_out_item.arg4_out     = r_out_ev.a4;
        o_out_item.has_event    = r_out_has;
        o_out_item.last_of_run  = r_out_last;
        o_out_item.stored_count = r_held;
    end

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CNT_W'(RING_DEPTH))
        else $error("stored count above ring depth");

    a_wslot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wslot <= IDX_W'(RING_DEPTH - 1))
        else $error("write slot outside ring");

    a_record_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_item.op == OP_RECORD))
        |=> ((r_state == ST_OUT) && !r_out_has && r_out_last))
        else $error("record did not produce a single acknowledgement");

    a_ack_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_OUT) && !r_out_has) |-> r_out_last)
        else $error("empty result not flagged as last");

    a_emit_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EM_CHK) |-> (r_total != '0))
        else $error("scan running with nothing left to emit");

endmodule

[hw/rtl/recent_event_trace_ring_top.sv]
// Channel   Dir  Handshake     Payload
// i_in      in   valid/ready   t_in_item: op, event fields, request_count, start_offset, filter
// o_out     out  valid/ready   t_out_item: event fields, has_event, last_of_run, stored_count
//
// Record and clear go straight from idle to the result transfer. A dump or range read walks the
// single store read port, with a read state and a check state per entry visited and a result
// transfer per entry emitted; a filtered dump first walks all held entries to count matches,
// plans, then walks again from the oldest held entry.
// Reset (synchronous, i_rst_n low) empties the ring; store contents need no clearing.
// i_in.ready is high only when no item is in progress; o_out stalls hold the sequencer.
// Depends on rets_pkg, rets_if, rets_store and rets_ctrl.
module recent_event_trace_ring_top
    import rets_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    rets_in_if.sink    i_in,
    rets_out_if.source o_out
);

    t_mem_req  mem_req;
    t_entry    rd_data;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    rets_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    rets_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_in_item   (i_in.data),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_out_item  (out_item),
        .o_mem_req   (mem_req),
        .i_rd_data   (rd_data)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.data  = out_item;

endmodule

[tb/tb_recent_event_trace_ring_top.sv]
// Self-checking bench for recent_event_trace_ring_top: directed and random record, dump,
// range-read and clear requests, checked against an in-bench ring predictor.
// Depends on rets_pkg, rets_if and the RTL of recent_event_trace_ring_top.
module tb_recent_event_trace_ring_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rets_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RST_CYCLES     = 4;
    localparam int N_RANDOM       = 205;
    localparam int CLEAR_FROM     = 150;
    localparam int HOLD_AT        = 40;
    localparam int HOLD_CYCLES    = 500;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 300;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        t_in_item cmd;
        bit       drain_first;
    } t_cmd_slot;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rets_in_if  req_ch ();
    rets_out_if rsp_ch ();

    recent_event_trace_ring_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    t_cmd_slot   trace_cmd_q[$];
    t_out_item   ring_reply_q[$];
    t_entry      model_store [RING_DEPTH];
    int unsigned model_wslot, model_held, gen_held;
    int unsigned cmds_accepted, n_cmds, n_directed;
    int unsigned replies_expected, replies_checked;
    int unsigned n_errors, n_acks, n_overwrites;
    int unsigned idle_cycles, hold_left;
    bit          hold_done;
    logic        timed_out;

    assign timed_out = (idle_cycles >= WATCHDOG_LIMIT);

    task automatic report_bad(string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS) $display("%s", msg);
    endtask

    task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v)
            report_bad($sformatf("result %0d: %s expected %h, got %h",
                                 replies_checked, name, want_v, got_v));
    endtask

    // Apply one request to the ring copy and queue the results it must produce.
    function automatic int unsigned ring_apply(t_in_item c);
        int unsigned req, base, take, hit_cnt, skip, seen, lim, slot, k;
        int unsigned picks[$];
        t_out_item   r;
        req  = (c.request_count > RING_DEPTH) ? RING_DEPTH : c.request_count;
        base = (model_wslot + RING_DEPTH - model_held) % RING_DEPTH;
        case (c.op)
            OP_RECORD: begin
                if (model_held == RING_DEPTH) n_overwrites++;
                model_store[model_wslot] = '{tm: c.time_stamp, src: c.source_id,
                                             code: c.event_code, sev: c.severity,
                                             a1: c.arg1, a2: c.arg2, a3: c.arg3, a4: c.arg4};
                model_wslot = (model_wslot + 1) % RING_DEPTH;
                if (model_held < RING_DEPTH) model_held++;
            end
            OP_CLEAR: begin
                model_wslot = 0;
                model_held  = 0;
            end
            OP_DUMP: begin
                if (req != 0 && c.filter_by_source) begin
                    hit_cnt = 0;
                    for (k = 0; k < model_held; k++)
                        if (model_store[(base + k) % RING_DEPTH].src == c.source_id) hit_cnt++;
                    // keep only the newest req hits, still oldest first
                    skip = (hit_cnt > req) ? hit_cnt - req : 0;
                    seen = 0;
                    for (k = 0; k < model_held; k++) begin
                        slot = (base + k) % RING_DEPTH;
                        if (model_store[slot].src == c.source_id) begin
                            if (seen >= skip) picks.push_back(slot);
                            seen++;
                        end
                    end
                end else if (req != 0) begin
                    take = (model_held < req) ? model_held : req;
                    for (k = 0; k < take; k++)
                        picks.push_back((base + model_held - take + k) % RING_DEPTH);
                end
            end
            OP_RANGE: begin
                if (req != 0 && c.start_offset < model_held) begin
                    lim = model_held - c.start_offset;
                    if (lim > req) lim = req;
                    for (k = 0; k < lim; k++)
                        picks.push_back((base + c.start_offset + k) % RING_DEPTH);
                end
            end
        endcase
        r = '0;
        r.stored_count = model_held[CNT_W-1:0];
        if (picks.size() == 0) begin
            r.last_of_run = 1'b1;
            ring_reply_q.push_back(r);
            n_acks++;
            return 1;
        end
        r.has_event = 1'b1;
        foreach (picks[j]) begin
            r.time_out     = model_store[picks[j]].tm;
            r.source_out   = model_store[picks[j]].src;
            r.event_out    = model_store[picks[j]].code;
            r.severity_out = model_store[picks[j]].sev;
            r.arg1_out     = model_store[picks[j]].a1;
            r.arg2_out     = model_store[picks[j]].a2;
            r.arg3_out     = model_store[picks[j]].a3;
            r.arg4_out     = model_store[picks[j]].a4;
            r.last_of_run  = (j == picks.size() - 1);
            ring_reply_q.push_back(r);
        end
        return picks.size();
    endfunction

    function automatic int unsigned idle_pct(bit rx_side);
        if (cmds_accepted < n_cmds / 3) return rx_side ? 72 : 29;
        if (cmds_accepted < 2 * n_cmds / 3) return rx_side ? 29 : 72;
        return 0;
    endfunction

    function automatic logic [15:0] pool_src();
        case ($urandom_range(3))
            0:       return 16'h0001;
            1:       return 16'h00A5;
            2:       return 16'h7E00;
            default: return 16'hFFFF;
        endcase
    endfunction

    // Random request; sources come mostly from a small pool so filtered dumps hit.
    function automatic t_in_item pick_cmd(t_op op);
        t_in_item    c;
        int unsigned sel;
        c.op         = op;
        c.time_stamp = $urandom();
        c.source_id  = ($urandom_range(99) < 75) ? pool_src() : 16'($urandom());
        c.event_code = 8'($urandom());
        c.severity   = ($urandom_range(99) < 70) ? 8'($urandom_range(3)) : 8'($urandom());
        c.arg1       = $urandom();
        c.arg2       = $urandom();
        c.arg3       = $urandom();
        c.arg4       = $urandom();
        sel = $urandom_range(99);
        if (sel < 5)       c.request_count = '0;
        else if (sel < 60) c.request_count = 16'($urandom_range(8, 1));
        else if (sel < 80) c.request_count = 16'($urandom_range(RING_DEPTH, 9));
        else if (sel < 93) c.request_count = 16'($urandom());
        else               c.request_count = 16'hFFFF;
        sel = $urandom_range(99);
        if (gen_held != 0 && sel < 70) c.start_offset = 16'($urandom_range(gen_held - 1));
        else if (sel < 88)             c.start_offset = 16'(gen_held + $urandom_range(3));
        else                           c.start_offset = 16'($urandom());
        c.filter_by_source = 1'($urandom_range(1));
        return c;
    endfunction

    function automatic t_in_item shaped(t_op op, logic [15:0] req, logic [15:0] off,
                                        logic filt, logic [15:0] src);
        t_in_item c;
        c                  = pick_cmd(op);
        c.request_count    = req;
        c.start_offset     = off;
        c.filter_by_source = filt;
        c.source_id        = src;
        return c;
    endfunction

    task automatic queue_cmd(t_in_item c, bit drain);
        if (c.op == OP_RECORD && gen_held < RING_DEPTH) gen_held++;
        if (c.op == OP_CLEAR) gen_held = 0;
        trace_cmd_q.push_back('{cmd: c, drain_first: drain});
    endtask

    // Request driver: hold an offer until it transfers, then pull the next one.
    always @(posedge i_clk) begin
        int unsigned owed;
        bit          took;
        if (!i_rst_n) begin
            req_ch.valid     <= 1'b0;
            cmds_accepted    <= 0;
            replies_expected <= 0;
        end else begin
            owed = replies_expected;
            took = req_ch.valid && req_ch.ready;
            if (took) begin
                owed += ring_apply(req_ch.data);
                void'(trace_cmd_q.pop_front());
                cmds_accepted    <= cmds_accepted + 1;
                replies_expected <= owed;
            end
            if (!req_ch.valid || took) begin
                if (trace_cmd_q.size() == 0
                    || (trace_cmd_q[0].drain_first && owed != replies_checked)
                    || $urandom_range(99) < idle_pct(1'b0)) begin
                    req_ch.valid <= 1'b0;
                end else begin
                    req_ch.valid <= 1'b1;
                    req_ch.data  <= trace_cmd_q[0].cmd;
                end
            end
        end
    end

    // Result monitor: compare every transfer with the oldest expected result.
    always @(posedge i_clk) begin
        t_out_item want, got;
        if (!i_rst_n) begin
            rsp_ch.ready    <= 1'b0;
            replies_checked <= 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = rsp_ch.data;
                replies_checked <= replies_checked + 1;
                if (ring_reply_q.size() == 0) begin
                    report_bad($sformatf("result %0d arrived with nothing expected: %h",
                                         replies_checked, got));
                end else begin
                    want = ring_reply_q.pop_front();
                    check_field("time_out",     want.time_out,     got.time_out);
                    check_field("source_out",   want.source_out,   got.source_out);
                    check_field("event_out",    want.event_out,    got.event_out);
                    check_field("severity_out", want.severity_out, got.severity_out);
                    check_field("arg1_out",     want.arg1_out,     got.arg1_out);
                    check_field("arg2_out",     want.arg2_out,     got.arg2_out);
                    check_field("arg3_out",     want.arg3_out,     got.arg3_out);
                    check_field("arg4_out",     want.arg4_out,     got.arg4_out);
                    check_field("has_event",    want.has_event,    got.has_event);
                    check_field("last_of_run",  want.last_of_run,  got.last_of_run);
                    check_field("stored_count", want.stored_count, got.stored_count);
                end
            end
            rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    // One long result back-pressure stretch so the ring stalls its request side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && cmds_accepted >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        t_in_item    c;
        t_op         op;
        int unsigned k, sel, tail;
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;

        // empty ring, field extremes, every op and each corner of dump and range
        queue_cmd(shaped(OP_DUMP,  16'd5, 16'd0, 1'b0, 16'h0001), 1'b0);
        queue_cmd(shaped(OP_RANGE, 16'd5, 16'd0, 1'b0, 16'h0001), 1'b0);
        queue_cmd(shaped(OP_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF), 1'b0);
        c = '1;
        c.op = OP_RECORD;
        queue_cmd(c, 1'b0);
        c = '0;
        c.op = OP_RECORD;
        queue_cmd(c, 1'b0);
        queue_cmd(shaped(OP_RECORD, 16'd0, 16'd0, 1'b0, 16'h00A5), 1'b0);
        queue_cmd(shaped(OP_RECORD, 16'd1, 16'd1, 1'b1, 16'h00A5), 1'b0);
        queue_cmd(shaped(OP_DUMP,  16'd0, 16'd0, 1'b0, 16'h0001), 1'b0);
        queue_cmd(shaped(OP_DUMP,  16'hFFFF, 16'd0, 1'b0, 16'h0001), 1'b0);
        queue_cmd(shaped(OP_DUMP,  16'd2, 16'd0, 1'b0, 16'h0001), 1'b0);
        queue_cmd(shaped(OP_RANGE, 16'd1, 16'd0, 1'b0, 16'h0001), 1'b0);
        queue_cmd(shaped(OP_RANGE, 16'hFFFF, 16'd1, 1'b0, 16'h0001), 1'b0);
        queue_cmd(shaped(OP_RANGE, 16'd3, 16'd4, 1'b0, 16'h0001), 1'b0);
        queue_cmd(shaped(OP_RANGE, 16'd3, 16'hFFFF, 1'b0, 16'h0001), 1'b0);
        queue_cmd(shaped(OP_RANGE, 16'd0, 16'd0, 1'b0, 16'h0001), 1'b0);
        queue_cmd(shaped(OP_DUMP,  16'd1, 16'd0, 1'b1, 16'h00A5), 1'b0);
        queue_cmd(shaped(OP_DUMP,  16'd64, 16'd0, 1'b1, 16'h00A5), 1'b0);
        queue_cmd(shaped(OP_DUMP,  16'd64, 16'd0, 1'b1, 16'h1234), 1'b0);
        queue_cmd(shaped(OP_DUMP,  16'd0, 16'd0, 1'b1, 16'h00A5), 1'b0);
        queue_cmd(shaped(OP_DUMP,  16'hFFFF, 16'd0, 1'b1, 16'hFFFF), 1'b0);
        queue_cmd(shaped(OP_RANGE, 16'd2, 16'd1, 1'b1, 16'h00A5), 1'b0);
        queue_cmd(shaped(OP_CLEAR, 16'd0, 16'd0, 1'b0, 16'h0000), 1'b0);
        queue_cmd(shaped(OP_DUMP,  16'd64, 16'd0, 1'b0, 16'h0001), 1'b0);
        queue_cmd(shaped(OP_RECORD, 16'd0, 16'd0, 1'b0, 16'h7E00), 1'b0);
        queue_cmd(shaped(OP_RANGE, 16'd64, 16'd0, 1'b0, 16'h0001), 1'b0);
        n_directed = trace_cmd_q.size();

        // no clears early on, so the ring wraps and overwrites before it is emptied
        for (k = 0; k < N_RANDOM; k++) begin
            sel = $urandom_range(99);
            if (sel < 55)                      op = OP_RECORD;
            else if (sel < 76)                 op = OP_DUMP;
            else if (sel < 96 || k < CLEAR_FROM) op = OP_RANGE;
            else                               op = OP_CLEAR;
            queue_cmd(pick_cmd(op), k == 0 || k == CLEAR_FROM);
        end
        n_cmds = trace_cmd_q.size();

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!timed_out && (cmds_accepted != n_cmds || replies_checked != replies_expected))
            @(posedge i_clk);
        tail = 0;
        while (!timed_out && tail < TAIL_CYCLES) begin
            @(posedge i_clk);
            tail++;
        end

        if (timed_out) begin
            $display("watchdog: %0d cycles without a transfer", idle_cycles);
            $display("tb_recent_event_trace_ring_top: done, errors");
        end else begin
            if (ring_reply_q.size() != 0)
                report_bad($sformatf("%0d expected results never arrived", ring_reply_q.size()));
            $display("summary: %0d requests (%0d directed), %0d results, %0d acks, %0d overwrites",
                     cmds_accepted, n_directed, replies_checked, n_acks, n_overwrites);
            $display("summary: three stall mixes, one %0d-cycle result hold, %0d mismatches",
                     HOLD_CYCLES, n_errors);
            if (n_errors == 0)
                $display("tb_recent_event_trace_ring_top: done, clean");
            else
                $display("tb_recent_event_trace_ring_top: done, errors");
        end
        $finish;
    end

endmodule
